### design/cfr_pkg.sv
package cfr_pkg;

    localparam int PixW  = 8;
    localparam int ProdW = 20;
    localparam int SumW  = 10;
    localparam int CntW  = 3;
    localparam int QDepth = 4;
    localparam int QAw   = 2;
    localparam int QCw   = 3;
    localparam int MulW  = 16;
    localparam int AccW  = 18;

    localparam logic [CntW-1:0] FootprintMax = 3'd4;
    localparam logic [QCw-1:0]  QFull        = 3'd4;

    typedef struct packed {
        logic [PixW-1:0] red;
        logic [PixW-1:0] green;
        logic [PixW-1:0] blue;
        logic            last;
    } cfr_pix_t;

    typedef struct packed {
        logic     valid;
        cfr_pix_t pix;
    } cfr_push_t;

    function automatic logic [PixW-1:0] clip_u8(input logic signed [ProdW-1:0] v);
        logic [PixW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 255) begin
            r = 8'd255;
        end else begin
            r = v[PixW-1:0];
        end
        return r;
    endfunction

endpackage

### design/cfr_front.sv
module cfr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output cfr_pkg::cfr_push_t push
);
    import cfr_pkg::*;

    logic                    a_vld_reg, a_vld_next;
    logic signed [ProdW-1:0] p298c_reg, p409e_reg, p100d_reg, p208e_reg, p516d_reg;
    logic                    last_reg;
    logic signed [9:0]       c, d, e;
    logic                    fire, advance;
    logic signed [ProdW-1:0] r_acc, g_acc, b_acc;

    assign c = signed'({2'b00, s_tdata[7:0]}) - 10'sd16;
    assign d = signed'({2'b00, s_tdata[15:8]}) - 10'sd128;
    assign e = signed'({2'b00, s_tdata[23:16]}) - 10'sd128;

    assign advance  = a_vld_reg && !q_full;
    assign s_tready = !a_vld_reg || !q_full;
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        if (fire) begin
            a_vld_next = 1'b1;
        end else if (advance) begin
            a_vld_next = 1'b0;
        end else begin
            a_vld_next = a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            p298c_reg <= ProdW'(c) * 20'sd298;
            p409e_reg <= ProdW'(e) * 20'sd409;
            p100d_reg <= ProdW'(d) * 20'sd100;
            p208e_reg <= ProdW'(e) * 20'sd208;
            p516d_reg <= ProdW'(d) * 20'sd516;
            last_reg  <= s_tlast;
        end
    end

    assign r_acc = p298c_reg + p409e_reg + 20'sd128;
    assign g_acc = p298c_reg - p100d_reg - p208e_reg + 20'sd128;
    assign b_acc = p298c_reg + p516d_reg + 20'sd128;

    assign push.valid     = a_vld_reg;
    assign push.pix.red   = clip_u8(r_acc >>> 8);
    assign push.pix.green = clip_u8(g_acc >>> 8);
    assign push.pix.blue  = clip_u8(b_acc >>> 8);
    assign push.pix.last  = last_reg;

endmodule

### design/cfr_queue.sv
module cfr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfr_pkg::cfr_push_t push,
    output logic               full,
    output cfr_pkg::cfr_push_t head,
    input  logic               pop
);
    import cfr_pkg::*;

    cfr_pix_t       mem_reg [QDepth];
    logic [QAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCw-1:0] cnt_reg;
    logic           do_push, do_pop;

    assign full       = (cnt_reg == QFull);
    assign head.valid = (cnt_reg != '0);
    assign head.pix   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.pix;
        end
    end

endmodule

### design/cfr_back.sv
module cfr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfr_pkg::cfr_push_t head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata
);
    import cfr_pkg::*;

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_MUL = 2'd2;
    localparam logic [1:0] ST_FIN = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [SumW-1:0]  rsum_reg, gsum_reg, bsum_reg;
    logic [SumW-1:0]  rsum_next, gsum_next, bsum_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [PixW-1:0]  ravg_reg, gavg_reg, bavg_reg;
    logic [MulW-1:0]  p38r_reg, p74g_reg, p112b_reg, p112r_reg, p94g_reg, p18b_reg;
    logic             out_vld_reg, out_vld_next;
    logic [15:0]      out_data_reg;
    logic             out_free, load_out;
    logic [PixW-1:0]  rdiv, gdiv, bdiv;
    logic signed [AccW-1:0] u_acc, v_acc, u_fin, v_fin;

    function automatic logic [PixW-1:0] div_count(input logic [SumW-1:0] x,
                                                  input logic [CntW-1:0] n);
        logic [19:0]     prod;
        logic [PixW-1:0] q;
        prod = 20'(x) * 20'd683;
        unique case (n)
            3'd2:    q = x[PixW:1];
            3'd3:    q = prod[18:11];
            3'd4:    q = x[PixW+1:2];
            default: q = x[PixW-1:0];
        endcase
        return q;
    endfunction

    assign out_free = !out_vld_reg || m_tready;
    assign pop      = (state_reg == ST_ACC) && head.valid;
    assign load_out = (state_reg == ST_FIN) && out_free;

    assign rdiv = div_count(rsum_reg, cnt_reg);
    assign gdiv = div_count(gsum_reg, cnt_reg);
    assign bdiv = div_count(bsum_reg, cnt_reg);

    assign u_acc = AccW'(p112b_reg) - AccW'(p38r_reg) - AccW'(p74g_reg) + 18'sd128;
    assign v_acc = AccW'(p112r_reg) - AccW'(p94g_reg) - AccW'(p18b_reg) + 18'sd128;
    assign u_fin = (u_acc >>> 8) + 18'sd128;
    assign v_fin = (v_acc >>> 8) + 18'sd128;

    always_comb begin
        state_next   = state_reg;
        rsum_next    = rsum_reg;
        gsum_next    = gsum_reg;
        bsum_next    = bsum_reg;
        cnt_next     = cnt_reg;
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACC: begin
                if (pop) begin
                    if (cnt_reg < FootprintMax) begin
                        rsum_next = rsum_reg + SumW'(head.pix.red);
                        gsum_next = gsum_reg + SumW'(head.pix.green);
                        bsum_next = bsum_reg + SumW'(head.pix.blue);
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    if (head.pix.last) begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rsum_next  = '0;
                gsum_next  = '0;
                bsum_next  = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (load_out) begin
                    out_vld_next = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            rsum_reg    <= '0;
            gsum_reg    <= '0;
            bsum_reg    <= '0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rsum_reg    <= rsum_next;
            gsum_reg    <= gsum_next;
            bsum_reg    <= bsum_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV) begin
            ravg_reg <= rdiv;
            gavg_reg <= gdiv;
            bavg_reg <= bdiv;
        end
        if (state_reg == ST_MUL) begin
            p38r_reg  <= MulW'(ravg_reg) * 16'd38;
            p74g_reg  <= MulW'(gavg_reg) * 16'd74;
            p112b_reg <= MulW'(bavg_reg) * 16'd112;
            p112r_reg <= MulW'(ravg_reg) * 16'd112;
            p94g_reg  <= MulW'(gavg_reg) * 16'd94;
            p18b_reg  <= MulW'(bavg_reg) * 16'd18;
        end
        if (load_out) begin
            out_data_reg <= {clip_u8(ProdW'(v_fin)), clip_u8(ProdW'(u_fin))};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

### design/chroma_footprint_reencode_unit.sv
// Throughput: the input side takes one word per cycle into a four-entry queue
// while the queue is not full; the accumulator drains one pixel per cycle while
// in its accumulate state, then passes through the divide, multiply and finish
// states per footprint, and the finish state waits until the output is free.
// Reset: synchronous on aresetn low; sums, count, queue and output valid clear.
module chroma_footprint_reencode_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // luma, blue_diff, red_diff
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // blue_diff_out, red_diff_out
);
    import cfr_pkg::*;

    cfr_push_t push;
    cfr_push_t head;
    logic      q_full;
    logic      pop;

    cfr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push)
    );

    cfr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    cfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### design/cfr_checker.sv
module cfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic [3:0] pend_reg;
    logic       last_in, word_out;

    assign last_in  = s_tvalid && s_tready && s_tlast;
    assign word_out = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (last_in && !word_out) begin
            pend_reg <= pend_reg + 1'b1;
        end else if (word_out && !last_in) begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid not cleared by reset");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 4'd0)
        else $error("result word without a finished footprint");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 4'd7)
        else $error("more footprints in flight than the design can hold");

endmodule

bind chroma_footprint_reencode_unit cfr_checker u_cfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
